// ===== sv/gamepad_state_to_events_macros.svh =====
`ifndef GAMEPAD_STATE_TO_EVENTS_MACROS_SVH
`define GAMEPAD_STATE_TO_EVENTS_MACROS_SVH

// same-cycle implication, reset masked
`define GSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gse assertion failed");

// next-cycle implication, reset masked
`define GSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gse assertion failed");

`endif

// ===== sv/gse_pkg.sv =====
package gse_pkg;

  localparam int FRAC_BITS = 15;
  localparam int BTN_BITS  = 16;
  localparam int NUM_W     = 17;
  localparam int DVD_W     = NUM_W + FRAC_BITS;

  localparam logic [7:0]  TRIG_FULL = 8'd255;
  localparam logic [15:0] AXIS_FULL = 16'd32767;
  localparam logic [16:0] Q_ONE     = 17'd32768;
  localparam logic [16:0] Q_MAXPOS  = 17'd32767;

  typedef struct packed {
    logic               read_ok;
    logic [31:0]        packet_number;
    logic [15:0]        button_bits;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] left_stick_x;
    logic signed [15:0] left_stick_y;
    logic signed [15:0] right_stick_x;
    logic signed [15:0] right_stick_y;
    logic [31:0]        time_stamp;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [3:0]         button_index;
    logic               pressed;
    logic [15:0]        trigger_level;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic [31:0]        event_time;
    logic               last_event;
  } out_beat_t;

  typedef enum logic [1:0] {
    CFG_TRIG_DZ,
    CFG_LEFT_DZ,
    CFG_RIGHT_DZ,
    CFG_BTN_MASK
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_BUTTON,
    EV_LEFT_TRIG,
    EV_RIGHT_TRIG,
    EV_LEFT_STICK,
    EV_RIGHT_STICK
  } ev_kind_t;

  typedef enum logic [2:0] {
    U_LT,
    U_RT,
    U_LX,
    U_LY,
    U_RX,
    U_RY,
    U_END
  } unit_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BTN,
    S_SEL,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [16:0] quo;
  } div_res_t;

endpackage

// ===== sv/gse_div.sv =====
module gse_div import gse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [15:0]       den,
  output div_res_t          res
);

  logic [DVD_W-1:0] dvd_r;
  logic [15:0]      rem_r;
  logic [15:0]      den_r;
  logic [16:0]      q_r;
  logic             ovf_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [16:0] trial;
  logic        ge;
  logic [16:0] diff;
  logic        rnd;
  logic [17:0] sum;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num, {FRAC_BITS{1'b0}}};
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? diff[15:0] : trial[15:0];
      q_r   <= {q_r[15:0], ge};
      ovf_r <= ovf_r | q_r[16];
    end
  end

  assign rnd = {rem_r, 1'b0} >= {1'b0, den_r};
  assign sum = {1'b0, q_r} + 18'(rnd);

  assign res.done = done_r;
  assign res.ovf  = ovf_r | sum[17];
  assign res.quo  = sum[16:0];

endmodule

// ===== sv/gamepad_state_to_events.sv =====
// Gamepad snapshot to change events. A snapshot is taken only when the block
// is idle; a failed read or a repeated packet number is taken and dropped.
// Otherwise the block scans the 16 button bits one per cycle, holding on a
// changed bit while the output stalls, then runs each changed trigger and
// each axis of a changed stick through one shared bit-serial divider, except
// where the value lies in the dead zone or saturates. Events leave through a
// single output register; last_event marks the final event of a snapshot.
`include "gamepad_state_to_events_macros.svh"

module gamepad_state_to_events import gse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_beat,
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_beat,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_idx_t   cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  trig_dz_r;
  logic [14:0] left_dz_r;
  logic [14:0] right_dz_r;
  logic [15:0] btn_mask_r;

  logic [31:0] prev_pkt_r;
  logic [15:0] prev_btn_r;
  logic [7:0]  prev_lt_r, prev_rt_r;
  logic [15:0] prev_lx_r, prev_ly_r, prev_rx_r, prev_ry_r;

  logic [31:0] ts_r;
  logic [7:0]  lt_r, rt_r;
  logic [15:0] lx_r, ly_r, rx_r, ry_r;
  logic [15:0] diff_r, btn_r;
  logic [3:0]  btn_cnt_r;
  logic [3:0]  evm_r;
  unit_t       unit_r;
  state_t      state_r, state_nxt;

  logic        spec_zero_r, spec_sat_r, neg_r;
  logic [15:0] trig_val_r;
  logic [15:0] ax_r, ay_r;

  logic        out_valid_r;
  out_beat_t   out_beat_r;

  logic        fire, out_free, needed, adv, fin, is_trig, is_xaxis;
  logic        take, btn_emit, btn_adv, sel_go, div_start, unit_inc, ev_emit, val_store;
  logic        ev_last;
  ev_kind_t    ev_kind;

  logic [7:0]  t_sel;
  logic [15:0] raw_sel;
  logic [14:0] dz_sel;
  logic [16:0] mag;
  logic        op_zero, op_sat;
  logic [NUM_W-1:0] op_num;
  logic [15:0] op_den;

  div_res_t    div_res;
  logic [16:0] mag_q, lim;
  logic [15:0] trig_val, axis_val;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = in_beat.read_ok && (in_beat.packet_number != prev_pkt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_dz_r  <= 8'd30;
      left_dz_r  <= 15'd7849;
      right_dz_r <= 15'd8689;
      btn_mask_r <= 16'd62463;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRIG_DZ:  trig_dz_r  <= cfg_data[7:0];
        CFG_LEFT_DZ:  left_dz_r  <= cfg_data[14:0];
        CFG_RIGHT_DZ: right_dz_r <= cfg_data[14:0];
        CFG_BTN_MASK: btn_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (unit_r)
      U_LT, U_RT: needed = (unit_r == U_LT) ? evm_r[0] : evm_r[1];
      U_LX, U_LY: needed = evm_r[2];
      U_RX, U_RY: needed = evm_r[3];
      default:    needed = 1'b0;
    endcase
  end

  always_comb begin
    case (unit_r)
      U_LT:    begin ev_kind = EV_LEFT_TRIG;   ev_last = (evm_r[3:1] == 3'd0); end
      U_RT:    begin ev_kind = EV_RIGHT_TRIG;  ev_last = (evm_r[3:2] == 2'd0); end
      U_LY:    begin ev_kind = EV_LEFT_STICK;  ev_last = !evm_r[3]; end
      default: begin ev_kind = EV_RIGHT_STICK; ev_last = 1'b1; end
    endcase
  end

  assign is_trig  = (unit_r == U_LT) || (unit_r == U_RT);
  assign is_xaxis = (unit_r == U_LX) || (unit_r == U_RX);

  always_comb begin
    case (unit_r)
      U_LX:    raw_sel = lx_r;
      U_LY:    raw_sel = ly_r;
      U_RX:    raw_sel = rx_r;
      default: raw_sel = ry_r;
    endcase
  end

  assign t_sel  = (unit_r == U_LT) ? lt_r : rt_r;
  assign dz_sel = ((unit_r == U_LX) || (unit_r == U_LY)) ? left_dz_r : right_dz_r;
  assign mag    = raw_sel[15] ? (17'h10000 - {1'b0, raw_sel}) : {1'b0, raw_sel};

  always_comb begin
    if (is_trig) begin
      op_zero = (trig_dz_r == TRIG_FULL) || (t_sel < trig_dz_r);
      op_sat  = 1'b0;
      op_num  = NUM_W'(t_sel - trig_dz_r);
      op_den  = {8'd0, TRIG_FULL - trig_dz_r};
    end else begin
      op_zero = mag <= {2'b00, dz_sel};
      op_sat  = !op_zero && (dz_sel == AXIS_FULL[14:0]);
      op_num  = mag - {2'b00, dz_sel};
      op_den  = AXIS_FULL - {1'b0, dz_sel};
    end
  end

  gse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (op_num),
    .den   (op_den),
    .res   (div_res)
  );

  assign fin = spec_zero_r || spec_sat_r || div_res.done;
  assign adv = !diff_r[0] || out_free;
  assign lim = neg_r ? Q_ONE : Q_MAXPOS;

  always_comb begin
    if (spec_zero_r)
      mag_q = '0;
    else if (spec_sat_r || div_res.ovf || (div_res.quo > lim))
      mag_q = lim;
    else
      mag_q = div_res.quo;
  end

  assign axis_val = neg_r ? 16'(17'd0 - mag_q) : mag_q[15:0];

  always_comb begin
    if (spec_zero_r)
      trig_val = '0;
    else if (div_res.ovf || (div_res.quo > Q_ONE))
      trig_val = Q_ONE[15:0];
    else
      trig_val = div_res.quo[15:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && fire) state_nxt = S_BTN;
      S_BTN:  if (adv && (btn_cnt_r == 4'(BTN_BITS - 1))) state_nxt = S_SEL;
      S_SEL: begin
        if (unit_r == U_END) state_nxt = S_IDLE;
        else if (needed)     state_nxt = S_DIV;
      end
      S_DIV:  if (fin) state_nxt = is_xaxis ? S_SEL : S_EMIT;
      S_EMIT: if (out_free) state_nxt = S_SEL;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != S_IDLE);
    take      = (state_r == S_IDLE) && in_valid && fire;
    btn_adv   = (state_r == S_BTN) && adv;
    btn_emit  = (state_r == S_BTN) && diff_r[0] && out_free;
    sel_go    = (state_r == S_SEL) && (unit_r != U_END) && needed;
    div_start = sel_go && !op_zero && !op_sat;
    val_store = (state_r == S_DIV) && fin;
    ev_emit   = (state_r == S_EMIT) && out_free;
    unit_inc  = ((state_r == S_SEL) && (unit_r != U_END) && !needed) ||
                (val_store && is_xaxis) || ev_emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      unit_r      <= U_LT;
      btn_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      prev_pkt_r  <= '0;
      prev_btn_r  <= '0;
      prev_lt_r   <= '0;
      prev_rt_r   <= '0;
      prev_lx_r   <= '0;
      prev_ly_r   <= '0;
      prev_rx_r   <= '0;
      prev_ry_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        unit_r     <= U_LT;
        btn_cnt_r  <= '0;
        prev_pkt_r <= in_beat.packet_number;
        prev_btn_r <= in_beat.button_bits;
        prev_lt_r  <= in_beat.left_trigger;
        prev_rt_r  <= in_beat.right_trigger;
        prev_lx_r  <= in_beat.left_stick_x;
        prev_ly_r  <= in_beat.left_stick_y;
        prev_rx_r  <= in_beat.right_stick_x;
        prev_ry_r  <= in_beat.right_stick_y;
      end else begin
        if (btn_adv) btn_cnt_r <= btn_cnt_r + 4'd1;
        if (unit_inc) unit_r <= unit_t'(unit_r + 3'd1);
      end
      if (btn_emit || ev_emit) out_valid_r <= 1'b1;
      else if (!out_stall)     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ts_r   <= in_beat.time_stamp;
      lt_r   <= in_beat.left_trigger;
      rt_r   <= in_beat.right_trigger;
      lx_r   <= in_beat.left_stick_x;
      ly_r   <= in_beat.left_stick_y;
      rx_r   <= in_beat.right_stick_x;
      ry_r   <= in_beat.right_stick_y;
      btn_r  <= in_beat.button_bits;
      diff_r <= (in_beat.button_bits ^ prev_btn_r) & btn_mask_r;
      evm_r  <= {(in_beat.right_stick_x != prev_rx_r) || (in_beat.right_stick_y != prev_ry_r),
                 (in_beat.left_stick_x != prev_lx_r) || (in_beat.left_stick_y != prev_ly_r),
                 in_beat.right_trigger != prev_rt_r,
                 in_beat.left_trigger != prev_lt_r};
    end else if (btn_adv) begin
      diff_r <= {1'b0, diff_r[15:1]};
      btn_r  <= {1'b0, btn_r[15:1]};
    end
    if (sel_go) begin
      spec_zero_r <= op_zero;
      spec_sat_r  <= op_sat;
      neg_r       <= !is_trig && raw_sel[15];
    end
    if (val_store) begin
      if (is_trig)       trig_val_r <= trig_val;
      else if (is_xaxis) ax_r <= axis_val;
      else               ay_r <= axis_val;
    end
    if (btn_emit) begin
      out_beat_r.event_kind    <= EV_BUTTON;
      out_beat_r.button_index  <= btn_cnt_r;
      out_beat_r.pressed       <= btn_r[0];
      out_beat_r.trigger_level <= '0;
      out_beat_r.axis_x        <= '0;
      out_beat_r.axis_y        <= '0;
      out_beat_r.event_time    <= ts_r;
      out_beat_r.last_event    <= (diff_r[15:1] == 15'd0) && (evm_r == 4'd0);
    end else if (ev_emit) begin
      out_beat_r.event_kind    <= ev_kind;
      out_beat_r.button_index  <= '0;
      out_beat_r.pressed       <= 1'b0;
      out_beat_r.trigger_level <= is_trig ? trig_val_r : 16'd0;
      out_beat_r.axis_x        <= is_trig ? 16'd0 : ax_r;
      out_beat_r.axis_y        <= is_trig ? 16'd0 : ay_r;
      out_beat_r.event_time    <= ts_r;
      out_beat_r.last_event    <= ev_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `GSE_ASSERT_NOW(a_accept_idle, in_valid && !in_stall, state_r == S_IDLE)
  `GSE_ASSERT_NOW(a_div_done_in_div, div_res.done, state_r == S_DIV)
  `GSE_ASSERT_NOW(a_button_beat_clean, out_valid_r && (out_beat_r.event_kind == EV_BUTTON), (out_beat_r.trigger_level == 16'd0) && (out_beat_r.axis_x == 16'd0) && (out_beat_r.axis_y == 16'd0))
  `GSE_ASSERT_NEXT(a_emit_sets_valid, btn_emit || ev_emit, out_valid_r)

endmodule
